/* src/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// NTC temperature package
// Shared request/result/configuration types and fixed-point constants.
// ----------------------------------------------------------------------------
package ntc_pkg;

  typedef struct packed {
    logic [11:0] sample;
    logic [1:0]  channel;
  } ntc_req_t;

  typedef struct packed {
    logic signed [15:0] temperature_centidegrees;
    logic               valid_res;
    logic [1:0]         channel_out;
  } ntc_res_t;

  typedef struct packed {
    logic [19:0]        pullup_ohms;
    logic [19:0]        nominal_ohms;
    logic [13:0]        beta_kelvin;
    logic [15:0]        nominal_centikelvin;
    logic signed [10:0] offset_centidegrees;
  } ntc_cfg_t;

  localparam int unsigned ADDR_W = 5;

  localparam logic [2:0] REG_PULLUP  = 3'd0;
  localparam logic [2:0] REG_NOMINAL = 3'd1;
  localparam logic [2:0] REG_BETA    = 3'd2;
  localparam logic [2:0] REG_T0      = 3'd3;
  localparam logic [2:0] REG_OFFSET  = 3'd4;

  localparam logic [19:0] PULLUP_RST  = 20'd10000;
  localparam logic [19:0] NOMINAL_RST = 20'd10000;
  localparam logic [13:0] BETA_RST    = 14'd3950;
  localparam logic [15:0] T0_RST      = 16'd29815;

  // ln(2) in Q0.32 and 100.0 in Q.32 (hundredths of a kelvin scale).
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [38:0] HUNDRED_Q32 = 39'h64_0000_0000;
  localparam int          ZERO_C_CK   = 27315;

  // Dividend widths of the ratio divider and the inverse-temperature dividers.
  localparam int unsigned RATIO_DVD_W = 49;
  localparam int unsigned INV_DVD_W   = 39;
  localparam int unsigned LOG_STAGES  = 24;

  // Registers from the request port to the result strobe.
  localparam int unsigned LATENCY = 2 + RATIO_DVD_W + 1 + (LOG_STAGES + 1) + 3
                                    + INV_DVD_W + 2 + INV_DVD_W + 1;

endpackage

/* src/ntc_div_pipe.sv */
// ----------------------------------------------------------------------------
// NTC pipelined divider
// Restoring unsigned division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ntc_div_pipe #(
  parameter int unsigned AW = 39,
  parameter int unsigned BW = 16,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [AW-1:0] dividend_i,
  input  logic [BW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [AW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic [BW-1:0] rem_q [AW];
  logic [AW-1:0] sh_q  [AW];
  logic [BW-1:0] dv_q  [AW];
  logic [SW-1:0] sd_q  [AW];
  logic          vl_q  [AW];

  for (genvar k = 0; k < AW; k++) begin : g_stage
    logic [BW-1:0] rem_in;
    logic [AW-1:0] sh_in;
    logic [BW-1:0] dv_in;
    logic [SW-1:0] sd_in;
    logic          vl_in;
    logic [BW:0]   trial;
    logic          ge;
    logic [BW-1:0] rem_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign sh_in  = dividend_i;
      assign dv_in  = divisor_i;
      assign sd_in  = side_i;
      assign vl_in  = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign sh_in  = sh_q[k-1];
      assign dv_in  = dv_q[k-1];
      assign sd_in  = sd_q[k-1];
      assign vl_in  = vl_q[k-1];
    end

    // Bring down the next dividend bit and try to subtract the divisor.
    assign trial = {rem_in, sh_in[AW-1]};
    assign ge    = trial >= {1'b0, dv_in};
    assign rem_d = ge ? BW'(trial - {1'b0, dv_in}) : trial[BW-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vl_q[k] <= 1'b0;
      end else begin
        vl_q[k] <= vl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      sh_q[k]  <= {sh_in[AW-2:0], ge};
      dv_q[k]  <= dv_in;
      sd_q[k]  <= sd_in;
    end
  end

  assign valid_o = vl_q[AW-1];
  assign quot_o  = sh_q[AW-1];
  assign side_o  = sd_q[AW-1];

endmodule

/* src/ntc_log2_pipe.sv */
// ----------------------------------------------------------------------------
// NTC log2 pipeline
// Normalizes a Q16.16 ratio, then squares the mantissa once per stage to
// produce one fraction bit of log2 per stage.
// ----------------------------------------------------------------------------
module ntc_log2_pipe #(
  parameter int unsigned SW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [31:0]   ratio_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [4:0]    exp_o,
  output logic [23:0]   frac_o,
  output logic [SW-1:0] side_o
);
  import ntc_pkg::*;

  logic [4:0]  lead;
  logic [31:0] norm;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (ratio_i[i]) begin
        lead = 5'(i);
      end
    end
    norm = ratio_i << (5'd31 - lead);
  end

  logic          vl_q [LOG_STAGES+1];
  logic [31:0]   m_q  [LOG_STAGES+1];
  logic [23:0]   fr_q [LOG_STAGES+1];
  logic [4:0]    ex_q [LOG_STAGES+1];
  logic [SW-1:0] sd_q [LOG_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q[0] <= 1'b0;
    end else begin
      vl_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q[0]  <= norm;
    fr_q[0] <= '0;
    ex_q[0] <= lead;
    sd_q[0] <= side_i;
  end

  for (genvar k = 1; k <= LOG_STAGES; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] top;
    logic [31:0] m_d;

    // The mantissa stays in [1,2); a square at or above 2 yields a one bit.
    assign sq  = 64'(m_q[k-1]) * 64'(m_q[k-1]);
    assign top = sq[63:31];
    assign m_d = top[32] ? top[32:1] : top[31:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vl_q[k] <= 1'b0;
      end else begin
        vl_q[k] <= vl_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      m_q[k]  <= m_d;
      fr_q[k] <= {fr_q[k-1][22:0], top[32]};
      ex_q[k] <= ex_q[k-1];
      sd_q[k] <= sd_q[k-1];
    end
  end

  assign valid_o = vl_q[LOG_STAGES];
  assign exp_o   = ex_q[LOG_STAGES];
  assign frac_o  = fr_q[LOG_STAGES];
  assign side_o  = sd_q[LOG_STAGES];

endmodule

/* src/ntc_regs.sv */
// ----------------------------------------------------------------------------
// NTC configuration registers
// APB-style register file holding the divider and thermistor constants.
// ----------------------------------------------------------------------------
module ntc_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ntc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output ntc_pkg::ntc_cfg_t     cfg_o
);
  import ntc_pkg::*;

  ntc_cfg_t cfg_q, cfg_d;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[4:2])
        REG_PULLUP:  cfg_d.pullup_ohms         = pwdata[19:0];
        REG_NOMINAL: cfg_d.nominal_ohms        = pwdata[19:0];
        REG_BETA:    cfg_d.beta_kelvin         = pwdata[13:0];
        REG_T0:      cfg_d.nominal_centikelvin = pwdata[15:0];
        REG_OFFSET:  cfg_d.offset_centidegrees = pwdata[10:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pullup_ohms         <= PULLUP_RST;
      cfg_q.nominal_ohms        <= NOMINAL_RST;
      cfg_q.beta_kelvin         <= BETA_RST;
      cfg_q.nominal_centikelvin <= T0_RST;
      cfg_q.offset_centidegrees <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PULLUP:  prdata = 32'(cfg_q.pullup_ohms);
      REG_NOMINAL: prdata = 32'(cfg_q.nominal_ohms);
      REG_BETA:    prdata = 32'(cfg_q.beta_kelvin);
      REG_T0:      prdata = 32'(cfg_q.nominal_centikelvin);
      REG_OFFSET:  prdata = {21'b0, cfg_q.offset_centidegrees};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* src/ntc_thermistor_temperature_core.sv */
// ----------------------------------------------------------------------------
// NTC thermistor temperature core
// Converts divider ADC samples to hundredths of a degree Celsius by the
// Beta equation in a fully pipelined fixed-point datapath.
// ----------------------------------------------------------------------------
//  Channel   Signals                               Direction
//  request   start, busy, req_i                    in  (accepted on start & !busy)
//  result    done_o, res_o                         out (one-cycle strobe)
//  config    psel, penable, pwrite, paddr, pwdata,  APB slave, pready tied high
//            prdata, pready
//
// One request is accepted every cycle; busy never rises. The delay from each
// request to its result is set by the depth of the ratio divider
// (49 bit stages), the log2 pipeline (25 stages) and two 39-stage dividers
// in series. Reset clears every valid bit at once, so in-flight requests are
// dropped and none is repeated; the result side cannot be stalled.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature_core #(
  parameter int unsigned ADC_FULL_SCALE = 4095
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ntc_pkg::ntc_req_t          req_i,
  output logic                       done_o,
  output ntc_pkg::ntc_res_t          res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ntc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ntc_pkg::*;

  localparam int unsigned FSW   = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned CW    = (FSW > 12) ? FSW : 12;
  localparam int unsigned DEN_W = 20 + FSW;
  localparam logic [CW-1:0] FS_C = CW'(ADC_FULL_SCALE);

  ntc_cfg_t cfg;

  ntc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy = 1'b0;

  logic        accept;
  logic [19:0] nom1;
  logic [13:0] beta1;
  logic [15:0] t01;

  assign accept = start && !busy;
  assign nom1   = (cfg.nominal_ohms == '0) ? 20'd1 : cfg.nominal_ohms;
  assign beta1  = (cfg.beta_kelvin == '0) ? 14'd1 : cfg.beta_kelvin;
  assign t01    = (cfg.nominal_centikelvin == '0) ? 16'd1 : cfg.nominal_centikelvin;

  // Stage 0: rail check and the two divider products.
  logic [CW-1:0]    raw_ext;
  logic [FSW-1:0]   fs_diff;
  logic             rail;
  logic [31:0]      pu_prod;
  logic [DEN_W-1:0] den_d;

  assign raw_ext = CW'(req_i.sample);
  assign rail    = (req_i.sample == '0) || (raw_ext >= FS_C);
  assign fs_diff = FSW'(FS_C - raw_ext);
  assign pu_prod = 32'(cfg.pullup_ohms) * 32'(req_i.sample);
  assign den_d   = DEN_W'(nom1) * DEN_W'(fs_diff);

  logic             s0_vld_q;
  logic [47:0]      s0_num_q;
  logic [DEN_W-1:0] s0_den_q;
  logic             s0_rail_q;
  logic [1:0]       s0_chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_num_q  <= {pu_prod, 16'b0};
    s0_den_q  <= den_d;
    s0_rail_q <= rail;
    s0_chan_q <= req_i.channel;
  end

  // Stage 1: add half the divisor so the quotient rounds half up.
  logic                   s1_vld_q;
  logic [RATIO_DVD_W-1:0] s1_dvd_q;
  logic [DEN_W-1:0]       s1_den_q;
  logic [2:0]             s1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dvd_q  <= RATIO_DVD_W'(s0_num_q) + RATIO_DVD_W'(s0_den_q >> 1);
    s1_den_q  <= s0_den_q;
    s1_side_q <= {s0_rail_q, s0_chan_q};
  end

  logic                   d1_vld;
  logic [RATIO_DVD_W-1:0] d1_quot;
  logic [2:0]             d1_side;

  ntc_div_pipe #(
    .AW (RATIO_DVD_W),
    .BW (DEN_W),
    .SW (3)
  ) u_div_ratio (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_vld_q),
    .dividend_i (s1_dvd_q),
    .divisor_i  (s1_den_q),
    .side_i     (s1_side_q),
    .valid_o    (d1_vld),
    .quot_o     (d1_quot),
    .side_o     (d1_side)
  );

  // Stage 2: clip the Q16.16 ratio into 32 bits.
  logic        ratio_lo, ratio_hi;
  logic        s2_vld_q;
  logic [31:0] s2_ratio_q;
  logic [3:0]  s2_side_q;

  assign ratio_lo = (d1_quot == '0);
  assign ratio_hi = |d1_quot[RATIO_DVD_W-1:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ratio_q <= ratio_lo ? 32'd1 : (ratio_hi ? '1 : d1_quot[31:0]);
    s2_side_q  <= {!(ratio_lo || ratio_hi), d1_side};
  end

  logic        lg_vld;
  logic [4:0]  lg_exp;
  logic [23:0] lg_frac;
  logic [3:0]  lg_side;

  ntc_log2_pipe #(
    .SW (4)
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_vld_q),
    .ratio_i (s2_ratio_q),
    .side_i  (s2_side_q),
    .valid_o (lg_vld),
    .exp_o   (lg_exp),
    .frac_o  (lg_frac),
    .side_o  (lg_side)
  );

  // Stage 3: log2 as sign and a Q5.24 magnitude.
  logic        lg_neg;
  logic [28:0] l2mag;
  logic        s3_vld_q, s3_neg_q;
  logic [28:0] s3_mag_q;
  logic [3:0]  s3_side_q;

  assign lg_neg = lg_exp < 5'd16;
  assign l2mag  = lg_neg ? (29'(5'd16 - lg_exp) << 24) - 29'(lg_frac)
                         : (29'(lg_exp - 5'd16) << 24) + 29'(lg_frac);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= lg_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_neg_q  <= lg_neg;
    s3_mag_q  <= l2mag;
    s3_side_q <= lg_side;
  end

  // Stage 4: times ln 2.
  logic        s4_vld_q, s4_neg_q;
  logic [60:0] s4_prod_q;
  logic [3:0]  s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_prod_q <= 61'(s3_mag_q) * 61'(LN2_Q32);
    s4_neg_q  <= s3_neg_q;
    s4_side_q <= s3_side_q;
  end

  // Stage 5: round ln to Q5.24 and form both inverse-temperature dividends.
  logic [60:0]          ln_sum;
  logic [28:0]          lnmag;
  logic                 s5_vld_q;
  logic [INV_DVD_W-1:0] s5_tdvd_q, s5_idvd_q;
  logic [15:0]          s5_beta_q, s5_t0_q;
  logic [1:0]           s5_flag_q;
  logic [2:0]           s5_side_q;

  assign ln_sum = s4_prod_q + (61'd1 << 31);
  assign lnmag  = ln_sum[60:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_tdvd_q <= INV_DVD_W'({lnmag, 8'b0}) + INV_DVD_W'(beta1 >> 1);
    s5_idvd_q <= HUNDRED_Q32 + INV_DVD_W'(t01 >> 1);
    s5_beta_q <= 16'(beta1);
    s5_t0_q   <= t01;
    s5_flag_q <= {s4_neg_q, s4_side_q[3]};
    s5_side_q <= s4_side_q[2:0];
  end

  logic                 d2_vld, d3_vld;
  logic [INV_DVD_W-1:0] tmag, inv0;
  logic [1:0]           d2_flag;
  logic [2:0]           d3_side;

  ntc_div_pipe #(
    .AW (INV_DVD_W),
    .BW (16),
    .SW (2)
  ) u_div_log (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s5_vld_q),
    .dividend_i (s5_tdvd_q),
    .divisor_i  (s5_beta_q),
    .side_i     (s5_flag_q),
    .valid_o    (d2_vld),
    .quot_o     (tmag),
    .side_o     (d2_flag)
  );

  ntc_div_pipe #(
    .AW (INV_DVD_W),
    .BW (16),
    .SW (3)
  ) u_div_inv0 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s5_vld_q),
    .dividend_i (s5_idvd_q),
    .divisor_i  (s5_t0_q),
    .side_i     (s5_side_q),
    .valid_o    (d3_vld),
    .quot_o     (inv0),
    .side_o     (d3_side)
  );

  // Stage 6: inverse temperature in Q0.32, clipped.
  logic signed [40:0] inv_sum;
  logic               inv_lo, inv_hi;
  logic               s6_vld_q;
  logic [31:0]        s6_inv_q;
  logic [3:0]         s6_side_q;

  assign inv_sum = d2_flag[1] ? $signed({2'b0, inv0}) - $signed({2'b0, tmag})
                              : $signed({2'b0, inv0}) + $signed({2'b0, tmag});
  assign inv_lo  = inv_sum < 41'sd1;
  assign inv_hi  = inv_sum > 41'sh0_FFFF_FFFF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= d2_vld && d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_inv_q  <= inv_lo ? 32'd1 : (inv_hi ? '1 : inv_sum[31:0]);
    s6_side_q <= {d2_flag[0] && !inv_lo && !inv_hi, d3_side};
  end

  // Stage 7: dividend for the reciprocal that gives centikelvin.
  logic                 s7_vld_q;
  logic [INV_DVD_W-1:0] s7_dvd_q;
  logic [31:0]          s7_inv_q;
  logic [3:0]           s7_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_dvd_q  <= HUNDRED_Q32 + INV_DVD_W'(s6_inv_q >> 1);
    s7_inv_q  <= s6_inv_q;
    s7_side_q <= s6_side_q;
  end

  logic                 d4_vld;
  logic [INV_DVD_W-1:0] tck;
  logic [3:0]           d4_side;

  ntc_div_pipe #(
    .AW (INV_DVD_W),
    .BW (32),
    .SW (4)
  ) u_div_temp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s7_vld_q),
    .dividend_i (s7_dvd_q),
    .divisor_i  (s7_inv_q),
    .side_i     (s7_side_q),
    .valid_o    (d4_vld),
    .quot_o     (tck),
    .side_o     (d4_side)
  );

  // Stage 8: Celsius with offset, saturated; rail samples read as zero.
  logic signed [40:0] cel;
  logic               cel_hi, cel_lo;
  ntc_res_t           res_d, res_q;
  logic               done_q;

  assign cel    = $signed({2'b0, tck}) - 41'(ZERO_C_CK)
                  + 41'(cfg.offset_centidegrees);
  assign cel_hi = cel > 41'sd32767;
  assign cel_lo = cel < -41'sd32768;

  always_comb begin
    res_d.channel_out = d4_side[1:0];
    if (d4_side[2]) begin
      res_d.temperature_centidegrees = '0;
      res_d.valid_res                = 1'b0;
    end else begin
      res_d.temperature_centidegrees = cel_hi ? 16'sh7FFF
                                     : (cel_lo ? 16'sh8000 : cel[15:0]);
      res_d.valid_res                = d4_side[3] && !cel_hi && !cel_lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d4_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* src/ntc_checker.sv */
// ----------------------------------------------------------------------------
// NTC core checker
// Port-level checks on request-to-result timing and tag pass-through.
// ----------------------------------------------------------------------------
module ntc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input ntc_pkg::ntc_req_t req_i,
  input logic              done_o,
  input ntc_pkg::ntc_res_t res_o
);
  import ntc_pkg::*;

  localparam int unsigned UPW = $clog2(LATENCY + 1);

  // Cycles since reset, saturating once the pipeline history is complete.
  logic [UPW-1:0] up_q;
  logic           full;

  assign full = (up_q == UPW'(LATENCY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q <= '0;
    end else if (!full) begin
      up_q <= up_q + 1'b1;
    end
  end

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_one_result_per_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == (full && $past(start && !busy, LATENCY)))
    else $error("result strobe does not match a request");

  a_channel_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && full) |-> res_o.channel_out == $past(req_i.channel, LATENCY))
    else $error("channel tag not carried through");

  a_zero_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && full && $past(req_i.sample == '0, LATENCY))
      |-> (!res_o.valid_res && res_o.temperature_centidegrees == '0))
    else $error("zero sample not reported invalid");

endmodule

bind ntc_thermistor_temperature_core ntc_checker u_ntc_checker (.*);
